// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a trigger at one edge is followed by a condition at the next edge.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bsr_pkg.sv -----
package bsr_pkg;

  // Block configuration.
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int GROUPS      = 2;

  // Field widths.
  localparam int CH_W     = 2;
  localparam int CH_AW    = $clog2(CHANNELS);
  localparam int IDX_W    = $clog2(SAMPLE_BITS);
  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int STAMP_W  = 64;
  localparam int COUNT_W  = 32;
  localparam int LIMIT_W  = 24;
  localparam int EXT_W    = ((SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W) + 2;

  // Last bit position of a converter word.
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_BITS - 1);

  // Configuration port.
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_INDEX_W = ADDR_W - 2;
  localparam logic [REG_INDEX_W-1:0] REG_JUMP_LIMIT = '0;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET    = 24'd10000;

  // One sampled bit from a converter.
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              data_bit;
    logic [TIME_W-1:0] now_time;
  } in_t;

  // One completed conversion.
  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STAMP_W-1:0]         timestamp;
    logic                       jump;
    logic [COUNT_W-1:0]         jump_count;
    logic [COUNT_W-1:0]         sample_count;
  } out_t;

  // Per-channel state entry held in the channel memory.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]        word;
    logic [IDX_W-1:0]              bit_index;
    logic [STAMP_W-1:0]            read_time;
    logic signed [SAMPLE_BITS-1:0] prev_sample;
    logic [COUNT_W-1:0]            jump_total;
    logic [COUNT_W-1:0]            sample_total;
  } chan_state_t;

  // Status of the result buffer toward the pipeline.
  typedef struct packed {
    logic room;
    logic full;
  } fifo_status_t;

endpackage

// ----- rtl/bridge_adc_serial_reader_top.sv -----
// Serial readout for four 24-bit bridge converters.
// Input channel (in_valid/in_ready/in_data): one sampled data bit of one
// converter per transaction, most significant bit first, with the free-running
// 32-bit timer. The timer is extended to 64 bits on a word's first bit, using
// the last extended time of the channel's pair group (channels 0/2 and 1/3).
// Output channel (out_valid/out_ready/out_data): one transaction per completed
// word with the sign-extended sample, its timestamp, a jump flag and the
// channel's jump and sample counters.
// Throughput: one input transaction per cycle while in_ready is high. The state
// of each channel and group lives in a memory with a registered read; the entry
// is read at acceptance, updated and written back in the next cycle, with
// forwarding for an item of the same channel or group that follows directly.
// A result is built in the pipeline stage and then held in the result buffer.
// Stall: a two-entry result buffer absorbs receiver stalls; in_ready drops
// only when that buffer, counting the staged item, has no room for another.
// Reset: all channel and group state reads as zero, jump_limit returns to
// 10000 and both channels are empty. jump_limit is written over the APB port.
`include "assert_macros.svh"

module bridge_adc_serial_reader_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bsr_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bsr_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bsr_pkg::DATA_W-1:0]   pwdata,
  output logic [bsr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bsr_pkg::*;

  // Configuration register.
  logic [LIMIT_W-1:0]     jump_limit;
  logic [REG_INDEX_W-1:0] reg_index;

  // Pipeline stage that holds the accepted item.
  logic        accept;
  logic        s1_valid;
  in_t         s1_item;
  logic        chan_ok;

  // Channel memory and forwarding.
  chan_state_t           ch_mem [CHANNELS];
  logic [CHANNELS-1:0]   ch_vld;
  chan_state_t           ch_rd_q;
  logic                  ch_rd_vld;
  logic                  ch_fwd_hit;
  chan_state_t           ch_fwd_data;
  logic                  ch_we;
  logic [CH_AW-1:0]      ch_wr_addr;
  logic [CH_AW-1:0]      ch_rd_addr;
  chan_state_t           ent;
  chan_state_t           ent_next;

  // Group time memory and forwarding.
  logic [STAMP_W-1:0]    grp_mem [GROUPS];
  logic [GROUPS-1:0]     grp_vld;
  logic [STAMP_W-1:0]    grp_rd_q;
  logic                  grp_rd_vld;
  logic                  grp_fwd_hit;
  logic [STAMP_W-1:0]    grp_fwd_data;
  logic                  grp_we;
  logic                  grp_wr_addr;
  logic                  grp_rd_addr;
  logic [STAMP_W-1:0]    grp_last;
  logic [STAMP_W-1:0]    grp_new;
  logic [TIME_W-1:0]     time_delta;

  // Word completion.
  logic                    first_bit;
  logic                    last_bit;
  logic [SAMPLE_BITS-1:0]  word_base;
  logic signed [EXT_W-1:0] s_ext;
  logic signed [EXT_W-1:0] diff;
  logic signed [EXT_W-1:0] lim;
  logic                    jump;

  // Result buffer.
  logic         res_push;
  out_t         res_data;
  fifo_status_t fifo_st;

  // APB register access.
  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign prdata    = (reg_index == REG_JUMP_LIMIT) ? DATA_W'(jump_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_JUMP_LIMIT)) begin
      jump_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Input handshake and the pipeline stage.
  assign in_ready = fifo_st.room;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
  end

  assign chan_ok     = (32'(s1_item.channel) < CHANNELS);
  assign ch_rd_addr  = in_data.channel[CH_AW-1:0];
  assign ch_wr_addr  = s1_item.channel[CH_AW-1:0];
  assign grp_rd_addr = in_data.channel[0];
  assign grp_wr_addr = s1_item.channel[0];
  assign ch_we       = s1_valid && chan_ok;
  assign grp_we      = ch_we && first_bit;

  // Channel memory: read at acceptance, write back from the stage.
  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[ch_wr_addr] <= ent_next;
    end
    ch_rd_q     <= ch_mem[ch_rd_addr];
    ch_fwd_data <= ent_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_vld     <= '0;
      ch_rd_vld  <= 1'b0;
      ch_fwd_hit <= 1'b0;
    end else begin
      if (ch_we) begin
        ch_vld[ch_wr_addr] <= 1'b1;
      end
      ch_rd_vld  <= ch_vld[ch_rd_addr];
      ch_fwd_hit <= ch_we && (ch_wr_addr == ch_rd_addr);
    end
  end

  // Group memory: same access pattern as the channel memory.
  always_ff @(posedge clk) begin
    if (grp_we) begin
      grp_mem[grp_wr_addr] <= grp_new;
    end
    grp_rd_q     <= grp_mem[grp_rd_addr];
    grp_fwd_data <= grp_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_vld     <= '0;
      grp_rd_vld  <= 1'b0;
      grp_fwd_hit <= 1'b0;
    end else begin
      if (grp_we) begin
        grp_vld[grp_wr_addr] <= 1'b1;
      end
      grp_rd_vld  <= grp_vld[grp_rd_addr];
      grp_fwd_hit <= grp_we && (grp_wr_addr == grp_rd_addr);
    end
  end

  // Current entries, with forwarding of a write that the read missed.
  always_comb begin
    if (ch_fwd_hit) begin
      ent = ch_fwd_data;
    end else if (ch_rd_vld) begin
      ent = ch_rd_q;
    end else begin
      ent = '0;
    end
    if (grp_fwd_hit) begin
      grp_last = grp_fwd_data;
    end else if (grp_rd_vld) begin
      grp_last = grp_rd_q;
    end else begin
      grp_last = '0;
    end
  end

  // Timestamp extension: the low-word difference is a signed step back.
  assign time_delta = grp_last[TIME_W-1:0] - s1_item.now_time;
  assign grp_new    = grp_last - {{(STAMP_W-TIME_W){time_delta[TIME_W-1]}}, time_delta};

  // Shift in the bit and update the entry.
  assign first_bit = (ent.bit_index == '0);
  assign last_bit  = (ent.bit_index == IDX_LAST);
  assign word_base = first_bit ? '0 : ent.word;
  assign s_ext     = EXT_W'(signed'(ent_next.word));
  assign diff      = s_ext - EXT_W'(ent.prev_sample);
  assign lim       = signed'({{(EXT_W-LIMIT_W){1'b0}}, jump_limit});
  assign jump      = (diff > lim) || (diff < -lim);

  always_comb begin
    ent_next      = ent;
    ent_next.word = {word_base[SAMPLE_BITS-2:0], s1_item.data_bit};
    if (first_bit) begin
      ent_next.read_time = grp_new;
    end
    if (last_bit) begin
      ent_next.bit_index    = '0;
      ent_next.prev_sample  = signed'(ent_next.word);
      ent_next.jump_total   = ent.jump_total + COUNT_W'(jump);
      ent_next.sample_total = ent.sample_total + COUNT_W'(1);
    end else begin
      ent_next.bit_index = ent.bit_index + IDX_W'(1);
    end
  end

  // Result of a completed word.
  assign res_push = ch_we && last_bit;

  always_comb begin
    res_data.out_channel  = s1_item.channel;
    res_data.sample       = s_ext[SAMPLE_W-1:0];
    res_data.timestamp    = ent_next.read_time;
    res_data.jump         = jump;
    res_data.jump_count   = ent_next.jump_total;
    res_data.sample_count = ent_next.sample_total;
  end

  bsr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .in_flight (s1_valid),
    .status    (fifo_st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Checks on the pipeline and the result buffer.
  `ASSERT_ALWAYS(a_no_overflow, !(res_push && fifo_st.full && !(out_valid && out_ready)), "result pushed into a full buffer")
  `ASSERT_NEXT(a_push_shows, res_push, out_valid, "pushed result not offered")
  `ASSERT_ALWAYS(a_ready_cause, in_ready || out_valid || s1_valid, "input stalled with nothing pending")

endmodule

// ----- rtl/bsr_out_fifo.sv -----
module bsr_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bsr_pkg::out_t         push_data,
  input  logic                  in_flight,
  output bsr_pkg::fifo_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bsr_pkg::out_t         out_data
);
  import bsr_pkg::*;

  out_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];

  // A new item may enter only if the buffer can still hold the result of
  // the item already in the pipeline plus its own.
  always_comb begin
    status.full = (count == 2'd2);
    status.room = (count == 2'd0) ||
                  ((count == 2'd1) && (pop || !in_flight)) ||
                  ((count == 2'd2) && pop && !in_flight);
  end

  // Buffer payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
